FILE: rtl/fourteen_segment_scan_driver_core_assert.svh
// Assertion macros for the fourteen-segment scan driver.
`ifndef FOURTEEN_SEGMENT_SCAN_DRIVER_CORE_ASSERT_SVH
`define FOURTEEN_SEGMENT_SCAN_DRIVER_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FSSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FSSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fssd_pkg.sv
// Package of types, codes and the font table of the fourteen-segment scan driver.
`default_nettype none
package fssd_pkg;

  localparam int MAX_DIGIT_COUNT = 8;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_APPEND = 2'd2;

  localparam logic [1:0] REG_DIGIT_COUNT  = 2'd0;
  localparam logic [1:0] REG_DISPLAY_TYPE = 2'd1;
  localparam logic [1:0] REG_TEST_MODE    = 2'd2;

  localparam logic [1:0] DT_COMMON_ANODE    = 2'd0;
  localparam logic [1:0] DT_CATHODE_DRIVER  = 2'd3;

  localparam logic [20:0] CODE_DOT   = 21'h2E;
  localparam logic [20:0] CODE_DASH  = 21'h2D;
  localparam logic [20:0] CODE_ZERO  = 21'h30;
  localparam logic [13:0] TEST_GLYPH  = 14'h3FFF;
  localparam logic [13:0] QUERY_GLYPH = 14'h3042;
  localparam logic [3:0]  NO_DIGIT    = 4'd8;
  localparam int          SEG_TOP     = 13;

  typedef struct packed {
    logic [3:0] digit_count;
    logic [1:0] display_type;
    logic       test_mode;
  } cfg_t;

  typedef struct packed {
    logic       emit;
    logic       lit;
    logic       on_line;
    logic [3:0] digit;
    logic       dp;
    logic       dash;
  } tick_t;

  function automatic logic [13:0] glyph_of(input logic [20:0] code, input logic test);
    logic [13:0] g;
    begin
      g = QUERY_GLYPH;
      if (test) begin
        g = (code == CODE_ZERO) ? TEST_GLYPH : 14'h0000;
      end else begin
        case (code)
          21'h20: g = 14'h0000;   21'h30: g = 14'h3F09;   21'h31: g = 14'h1808;
          21'h32: g = 14'h36C0;   21'h33: g = 14'h2CC8;   21'h34: g = 14'h19C0;
          21'h35: g = 14'h2DC0;   21'h36: g = 14'h2FC0;   21'h37: g = 14'h200A;
          21'h38: g = 14'h3FC0;   21'h39: g = 14'h3DC0;   21'h2D: g = 14'h00C0;
          21'h5F: g = 14'h0400;   21'h2B: g = 14'h00D2;   21'h3D: g = 14'h20C0;
          21'h7C: g = 14'h0012;   21'h2A: g = 14'h00FF;   21'h2F: g = 14'h0009;
          21'h3E: g = 14'h0021;   21'h3C: g = 14'h000C;   21'h3F: g = 14'h3042;
          21'h21: g = 14'h0410;   21'h40: g = 14'h3D42;   21'h23: g = 14'h3FD2;
          21'h2C: g = 14'h0001;   21'h60: g = 14'h0020;   21'h25: g = 14'h0909;
          21'h5E: g = 14'h3100;   21'h26: g = 14'h279E;   21'h28: g = 14'h000C;
          21'h29: g = 14'h0021;   21'h7B: g = 14'h1840;   21'h7D: g = 14'h0380;
          21'h5B: g = 14'h2700;   21'h5D: g = 14'h3C00;   21'h7E: g = 14'h0A84;
          21'h22: g = 14'h1100;   21'h20AC: g = 14'h2780; 21'hA2: g = 14'h2712;
          21'h24: g = 14'h2DD2;   21'hB0: g = 14'h31C0;   21'hA3: g = 14'h2780;
          21'h204B: g = 14'h3352; 21'h20A9: g = 14'h1BC5;
          21'h41: g = 14'h1849;   21'h61: g = 14'h3EC0;   21'h42: g = 14'h3C52;
          21'h62: g = 14'h0FC0;   21'h43: g = 14'h2700;   21'h63: g = 14'h06C0;
          21'h44: g = 14'h3C12;   21'h64: g = 14'h1EC0;   21'h45: g = 14'h27C0;
          21'h65: g = 14'h2788;   21'h46: g = 14'h23C0;   21'h66: g = 14'h2380;
          21'h47: g = 14'h2F40;   21'h67: g = 14'h3C60;   21'h48: g = 14'h1BC0;
          21'h68: g = 14'h0BC0;   21'h49: g = 14'h2412;   21'h69: g = 14'h2002;
          21'h4A: g = 14'h1C00;   21'h6A: g = 14'h1E00;   21'h4B: g = 14'h038C;
          21'h6B: g = 14'h038C;   21'h4C: g = 14'h0700;   21'h6C: g = 14'h0012;
          21'h4D: g = 14'h1B28;   21'h6D: g = 14'h0AC2;   21'h4E: g = 14'h1B24;
          21'h6E: g = 14'h0AC0;   21'h4F: g = 14'h3F00;   21'h6F: g = 14'h0EC0;
          21'h50: g = 14'h33C0;   21'h70: g = 14'h33C0;   21'h51: g = 14'h3F04;
          21'h71: g = 14'h39C0;   21'h52: g = 14'h33C4;   21'h72: g = 14'h02C0;
          21'h53: g = 14'h2DC0;   21'h73: g = 14'h2DC0;   21'h54: g = 14'h2012;
          21'h74: g = 14'h07C0;   21'h55: g = 14'h1F00;   21'h75: g = 14'h0E00;
          21'h56: g = 14'h0309;   21'h76: g = 14'h0309;   21'h57: g = 14'h1B05;
          21'h77: g = 14'h0E02;   21'h58: g = 14'h002D;   21'h78: g = 14'h002D;
          21'h59: g = 14'h002A;   21'h79: g = 14'h1DC0;   21'h5A: g = 14'h2409;
          21'h7A: g = 14'h2409;   21'hD7: g = 14'h002D;   21'h3BC: g = 14'h03D0;
          21'hB5: g = 14'h03D0;   21'h23FB: g = 14'h0ED0; 21'hB1: g = 14'h04D2;
          21'hA5: g = 14'h00EA;   21'h3A9: g = 14'h31C5;
          default: g = QUERY_GLYPH;
        endcase
      end
      return g;
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/fssd_cfg.sv
// Configuration registers of the scan driver behind an APB-style port.
`default_nettype none
module fssd_cfg
  import fssd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t       cfg_r;
  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[3:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.digit_count  <= 4'd8;
      cfg_r.display_type <= DT_COMMON_ANODE;
      cfg_r.test_mode    <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_DIGIT_COUNT:  cfg_r.digit_count  <= pwdata[3:0];
        REG_DISPLAY_TYPE: cfg_r.display_type <= pwdata[1:0];
        REG_TEST_MODE:    cfg_r.test_mode    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DIGIT_COUNT:  prdata = {28'd0, cfg_r.digit_count};
      REG_DISPLAY_TYPE: prdata = {30'd0, cfg_r.display_type};
      REG_TEST_MODE:    prdata = {31'd0, cfg_r.test_mode};
      default:          prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/fssd_store.sv
// Character store memory with a registered, write-through read port.
`default_nettype none
module fssd_store
  import fssd_pkg::*;
#(
  parameter int STORE_DEPTH = 16,
  parameter int AW = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [20:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [20:0]   rdata
);

  logic [20:0] mem [STORE_DEPTH];
  logic [20:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/fssd_ctrl.sv
// Buffer and scan position state, append handling and the per-tick digit choice.
`default_nettype none
module fssd_ctrl
  import fssd_pkg::*;
#(
  parameter int STORE_DEPTH = 16,
  parameter int AW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [1:0]    opcode,
  input  wire logic [20:0]   char_code,
  input  wire logic [3:0]    digit_count,
  output tick_t              tick,
  output logic               we,
  output logic      [AW-1:0] waddr,
  output logic      [20:0]   wdata,
  output logic      [AW-1:0] raddr
);

  localparam int PW = $clog2(STORE_DEPTH + 1);
  localparam int DW = $clog2(MAX_DIGIT_COUNT + 1);
  localparam int SW = ((PW > DW) ? PW : DW) + 2;

  typedef struct packed {
    logic          blank;
    logic [PW-1:0] rp;
    logic [PW-1:0] sp;
  } pick_t;

  logic [PW-1:0]          len_r, len_nxt, gc_r, gc_nxt;
  logic [PW-1:0]          rp_r, rp_nxt, sp_r, sp_nxt;
  logic [STORE_DEPTH-1:0] dots_r, dots_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [DW-1:0]          dc;
  logic [PW-1:0]          fill_n;
  logic [SW-1:0]          dig;
  pick_t                  cur, nxt;
  logic                   outside, full;

  function automatic logic dot_at(input logic [PW-1:0] i, input logic [PW-1:0] len,
                                  input logic [STORE_DEPTH-1:0] dots);
    return (i < len) && dots[i[AW-1:0]];
  endfunction

  function automatic pick_t pick(input logic [PW-1:0] rp, input logic [PW-1:0] sp,
                                 input logic [PW-1:0] len,
                                 input logic [STORE_DEPTH-1:0] dots);
    pick_t         p;
    logic [PW-1:0] rp1, sp1, rp2;
    begin
      rp1 = (rp >= len) ? '0 : rp;
      sp1 = (rp >= len) ? '0 : sp;
      rp2 = rp1 + PW'(dot_at(rp1, len, dots));
      if (rp2 >= len) begin
        p.rp = PW'(dot_at('0, len, dots));
        p.sp = '0;
      end else begin
        p.rp = rp2;
        p.sp = sp1;
      end
      p.blank = (p.rp >= len);
      return p;
    end
  endfunction

  always_comb begin
    if (digit_count == 4'd0) begin
      dc = DW'(1);
    end else if (int'(digit_count) > MAX_DIGIT_COUNT) begin
      dc = DW'(MAX_DIGIT_COUNT);
    end else begin
      dc = DW'(digit_count);
    end
    fill_n = (int'(dc) < STORE_DEPTH) ? PW'(dc) : PW'(STORE_DEPTH);
  end

  assign cur     = pick(rp_r, sp_r, len_r, dots_r);
  assign dig     = SW'(cur.sp) + SW'(dc) - SW'(gc_r);
  assign outside = dig[SW-1] || (dig >= SW'(dc));
  assign full    = ((char_code != CODE_DOT) && ((SW'(gc_r) + SW'(1)) > SW'(dc)))
                   || (int'(len_r) >= STORE_DEPTH);

  always_comb begin
    len_nxt  = len_r;
    gc_nxt   = gc_r;
    rp_nxt   = rp_r;
    sp_nxt   = sp_r;
    dots_nxt = dots_r;
    ovf_nxt  = ovf_r;
    we       = 1'b0;
    waddr    = len_r[AW-1:0];
    wdata    = char_code;
    tick     = '0;
    tick.digit = NO_DIGIT;
    if (accept) begin
      case (opcode)
        OP_CLEAR: begin
          len_nxt   = '0;
          gc_nxt    = '0;
          rp_nxt    = '0;
          sp_nxt    = '0;
          ovf_nxt   = 1'b0;
          tick.emit = 1'b1;
        end
        OP_APPEND: begin
          if ((char_code != 21'd0) && !ovf_r) begin
            if (full) begin
              ovf_nxt  = 1'b1;
              len_nxt  = fill_n;
              gc_nxt   = fill_n;
              dots_nxt = '0;
            end else begin
              we       = 1'b1;
              dots_nxt[len_r[AW-1:0]] = (char_code == CODE_DOT);
              len_nxt  = len_r + PW'(1);
              gc_nxt   = gc_r + PW'(char_code != CODE_DOT);
              rp_nxt   = '0;
              sp_nxt   = '0;
            end
          end
        end
        OP_TICK: begin
          tick.emit = 1'b1;
          if (len_r != '0) begin
            if (cur.blank) begin
              rp_nxt = cur.rp;
              sp_nxt = cur.sp;
            end else begin
              rp_nxt  = cur.rp + PW'(1);
              sp_nxt  = cur.sp + PW'(1);
              if (!outside) begin
                tick.lit     = 1'b1;
                tick.digit   = dig[3:0];
                tick.on_line = (dig < SW'(8));
                tick.dp      = dot_at(cur.rp + PW'(1), len_r, dots_r);
                tick.dash    = ovf_r;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign nxt   = pick(rp_nxt, sp_nxt, len_nxt, dots_nxt);
  assign raddr = nxt.rp[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      gc_r   <= '0;
      rp_r   <= '0;
      sp_r   <= '0;
      dots_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      gc_r   <= gc_nxt;
      rp_r   <= rp_nxt;
      sp_r   <= sp_nxt;
      dots_r <= dots_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/fourteen_segment_scan_driver_core.sv
// Top level of the fourteen-segment scan driver: control, store and result register.
// A new word can follow each accepted one while in_stall is low; a scan tick or a
// clear has its result in the output register in the cycle after acceptance, and
// an append gives none. The character shown on a tick is read from the store in the
// cycle before, at an address worked out from the state left by the previous word,
// so the single store read port allows one word per cycle while in_stall is low.
`default_nettype none
module fourteen_segment_scan_driver_core
  import fssd_pkg::*;
#(
  parameter int STORE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [20:0] in_char_code,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [7:0]  out_digit_lines,
  output logic      [14:0] out_segment_lines,
  output logic      [3:0]  out_lit_digit,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  `include "fourteen_segment_scan_driver_core_assert.svh"

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  cfg_t         cfg;
  tick_t        tick;
  logic         accept, we;
  logic [AW-1:0] waddr, raddr;
  logic [20:0]  wdata, rdata, code;
  logic [13:0]  glyph;
  logic [14:0]  segs_on;
  logic [7:0]   digs_on;
  logic         seg_on_hi, dig_on_hi;
  logic         out_valid_r, out_valid_nxt;
  logic [7:0]   digit_lines_r;
  logic [14:0]  segment_lines_r;
  logic [3:0]   lit_digit_r;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  fssd_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  fssd_ctrl #(
    .STORE_DEPTH(STORE_DEPTH), .AW(AW)
  ) u_ctrl (
    .clk, .rst_n, .accept, .opcode(in_opcode), .char_code(in_char_code),
    .digit_count(cfg.digit_count), .tick, .we, .waddr, .wdata, .raddr
  );

  fssd_store #(.STORE_DEPTH(STORE_DEPTH), .AW(AW)) u_store (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign code      = tick.dash ? CODE_DASH : rdata;
  assign glyph     = glyph_of(code, cfg.test_mode);
  assign seg_on_hi = cfg.display_type[0];
  assign dig_on_hi = (cfg.display_type == DT_COMMON_ANODE) ||
                     (cfg.display_type == DT_CATHODE_DRIVER);

  always_comb begin
    segs_on = '0;
    if (tick.lit) begin
      for (int k = 0; k <= SEG_TOP; k++) begin
        segs_on[k] = glyph[SEG_TOP - k];
      end
      segs_on[14] = tick.dp;
    end
    digs_on = tick.on_line ? (8'd1 << tick.digit[2:0]) : 8'd0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (accept && tick.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && tick.emit) begin
      digit_lines_r   <= dig_on_hi ? digs_on : ~digs_on;
      segment_lines_r <= seg_on_hi ? segs_on : ~segs_on;
      lit_digit_r     <= tick.digit;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_digit_lines   = digit_lines_r;
  assign out_segment_lines = segment_lines_r;
  assign out_lit_digit     = lit_digit_r;

  `FSSD_ASSERT_NEXT(a_clear_blank, accept && (in_opcode == OP_CLEAR),
    out_valid && (out_lit_digit == NO_DIGIT), "clear did not give a blank word")
  `FSSD_ASSERT_NOW(a_blank_lines, out_valid && (out_lit_digit == NO_DIGIT),
    (out_digit_lines == 8'h00) || (out_digit_lines == 8'hFF), "blank word lights a digit")
  `FSSD_ASSERT_NOW(a_one_digit, out_valid && (out_lit_digit < 4'd8),
    ($countones(out_digit_lines) == 1) || ($countones(out_digit_lines) == 7),
    "lit word does not select exactly one digit")

endmodule
`default_nettype wire
